// File: src/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// types, constants and the crc byte step shared by the request framer
// ----------------------------------------------------------------------------
package mrf_pkg;

  // request kinds
  typedef enum logic {
    OP_READ_HOLDING = 1'b0,
    OP_WRITE_SINGLE = 1'b1
  } mrf_op_t;

  // function codes placed in the second frame byte
  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;

  // crc-16/modbus, reflected polynomial, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SLAVE_ID_RESET = 8'h01;

  // frame layout: six header bytes then crc low and crc high
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned HDR_LEN   = 6;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(HDR_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic        op;
    logic [15:0] reg_addr;
    logic [15:0] reg_word;
  } mrf_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } mrf_out_t;

  // one byte through the crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/modbus_rtu_request_framer_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_unit
// builds an 8-byte modbus rtu request frame with crc-16/modbus per request
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Each
// request comes out as eight byte beats on out_valid/out_data, one beat per
// clock, in transmit order: slave id, function code, address high and low,
// word high and low, crc low, crc high (the last beat carries last). The
// receiver cannot stall, so the eight beats of a frame come on consecutive
// cycles. A taken request waits in an input register, moves into the byte
// serialiser, and each byte is registered again before it appears. One
// request is held in the input register while the serialiser sends the
// previous frame, so busy drops again as soon as the held request moves into
// the serialiser; a steady stream runs with no gap between frames, the
// serialiser sending one byte per clock. The crc is updated one byte per
// clock as the header bytes go out. cfg_we/cfg_wdata write the slave id
// (reset value 1); write it only while the block is idle.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_unit
  import mrf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mrf_in_t  in_data,
  output logic     out_valid,
  output mrf_out_t out_data,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata
);

  // slave id register
  logic [7:0] slave_id_r;

  // input holding register
  logic        hold_full_r, hold_full_nxt;
  logic [47:0] hold_hdr_r;

  // byte serialiser
  logic             ser_active_r, ser_active_nxt;
  logic [IDX_W-1:0] ser_idx_r, ser_idx_nxt;
  logic [47:0]      ser_hdr_r, ser_hdr_nxt;
  logic [15:0]      ser_crc_r, ser_crc_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       out_last_r, out_last_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;

  logic       accept;
  logic       ser_done;
  logic       load;
  logic [7:0] fn_code;
  logic [7:0] cur_byte;

  assign busy   = hold_full_r;
  assign accept = start && !hold_full_r;

  // the serialiser frees up on the crc high byte, so the next frame follows
  assign ser_done = ser_active_r && (ser_idx_r == IDX_LAST);
  assign load     = hold_full_r && (!ser_active_r || ser_done);

  assign fn_code = (in_data.op == OP_WRITE_SINGLE) ? FN_WRITE_SINGLE : FN_READ_HOLDING;

  // header bytes first, then crc low and high
  always_comb begin
    if (ser_idx_r < IDX_CRC_LO) begin
      cur_byte = ser_hdr_r[47:40];
    end else if (ser_idx_r == IDX_CRC_LO) begin
      cur_byte = ser_crc_r[7:0];
    end else begin
      cur_byte = ser_crc_r[15:8];
    end
  end

  always_comb begin
    hold_full_nxt  = hold_full_r;
    ser_active_nxt = ser_active_r;
    ser_idx_nxt    = ser_idx_r;
    ser_hdr_nxt    = ser_hdr_r;
    ser_crc_nxt    = ser_crc_r;

    if (accept) begin
      hold_full_nxt = 1'b1;
    end else if (load) begin
      hold_full_nxt = 1'b0;
    end

    if (ser_active_r) begin
      ser_idx_nxt = ser_idx_r + IDX_W'(1);
      ser_hdr_nxt = {ser_hdr_r[39:0], 8'h00};
      if (ser_idx_r < IDX_CRC_LO) begin
        ser_crc_nxt = crc_byte(ser_crc_r, ser_hdr_r[47:40]);
      end
    end

    if (load) begin
      ser_active_nxt = 1'b1;
      ser_idx_nxt    = '0;
      ser_hdr_nxt    = hold_hdr_r;
      ser_crc_nxt    = CRC_INIT;
    end else if (ser_done) begin
      ser_active_nxt = 1'b0;
    end

    out_valid_nxt = ser_active_r;
    out_last_nxt  = ser_done;
    out_byte_nxt  = cur_byte;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r   <= SLAVE_ID_RESET;
      hold_full_r  <= 1'b0;
      ser_active_r <= 1'b0;
      ser_idx_r    <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        slave_id_r <= cfg_wdata;
      end
      hold_full_r  <= hold_full_nxt;
      ser_active_r <= ser_active_nxt;
      ser_idx_r    <= ser_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_hdr_r <= {slave_id_r, fn_code, in_data.reg_addr, in_data.reg_word};
    end
    ser_hdr_r  <= ser_hdr_nxt;
    ser_crc_r  <= ser_crc_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_data.frame_byte = out_byte_r;
  assign out_data.last       = out_last_r;

endmodule

// File: src/mrf_checker.sv
// ----------------------------------------------------------------------------
// mrf_checker
// port-level checks on request acceptance and frame beat sequencing
// ----------------------------------------------------------------------------
module mrf_checker
  import mrf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input mrf_out_t   out_data
);

  // a taken request occupies the holding register for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after a request was taken");

  // last only marks a live beat
  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_data.last |-> out_valid)
    else $error("last without a beat");

  // a frame is never cut short
  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("frame broken before its last beat");

  // the last beat closes a frame: the beat before it and the frame's first beat must be live and not last
  a_frame_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> ($past(out_valid, 1) && $past(out_valid, 7)
      && !$past(out_data.last, 1) && !$past(out_data.last, 7)))
    else $error("frame shorter than eight beats");

endmodule

bind modbus_rtu_request_framer_unit mrf_checker u_mrf_checker (.*);
